@@ rtl/iae_pkg.sv @@
// ----------------------------------------------------------------------------
// iae_pkg
// Shared token format, character codes and operator codes for the
// expression evaluator.
// ----------------------------------------------------------------------------
package iae_pkg;

  // character codes
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_TIMES  = 8'h2A;
  localparam logic [7:0] CH_DIVIDE = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // pending operator codes
  localparam logic [1:0] OP_PLUS   = 2'd0;
  localparam logic [1:0] OP_MINUS  = 2'd1;
  localparam logic [1:0] OP_TIMES  = 2'd2;
  localparam logic [1:0] OP_DIVIDE = 2'd3;

  // token kinds
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_DIGIT = 2'd1;
  localparam logic [1:0] KIND_OP    = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  localparam int NUM_WIDTH   = 32;
  localparam int DEC_RADIX   = 10;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] digit;
    logic [1:0] op;
    logic       fin;
  } token_t;

endpackage

@@ rtl/iae_if.sv @@
// ----------------------------------------------------------------------------
// iae channel interfaces
// Valid/ready channels for input characters and evaluated results.
// ----------------------------------------------------------------------------
interface iae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

interface iae_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

@@ rtl/iae_front.sv @@
// ----------------------------------------------------------------------------
// iae_front
// Accepts characters and classifies them into digit, operator or other
// tokens for the token queue.
// ----------------------------------------------------------------------------
module iae_front import iae_pkg::*; (
  iae_in_if.sink   chars,
  input  logic     full,
  output logic     push,
  output token_t   tok
);

  logic [7:0] digit_off;

  // accept whenever the queue has room
  assign chars.ready = !full;
  assign push        = chars.valid && !full;

  assign digit_off = chars.ch - CH_ZERO;

  // classify the character
  always_comb begin
    tok.fin   = chars.last;
    tok.digit = digit_off[3:0];
    tok.op    = OP_PLUS;
    tok.kind  = KIND_OTHER;
    if (chars.ch >= CH_ZERO && chars.ch <= CH_NINE) begin
      tok.kind = KIND_DIGIT;
    end else begin
      case (chars.ch)
        CH_PLUS: begin
          tok.kind = KIND_OP;
          tok.op   = OP_PLUS;
        end
        CH_MINUS: begin
          tok.kind = KIND_OP;
          tok.op   = OP_MINUS;
        end
        CH_TIMES: begin
          tok.kind = KIND_OP;
          tok.op   = OP_TIMES;
        end
        CH_DIVIDE: begin
          tok.kind = KIND_OP;
          tok.op   = OP_DIVIDE;
        end
        default: begin
          tok.kind = KIND_OTHER;
        end
      endcase
    end
  end

endmodule

@@ rtl/iae_queue.sv @@
// ----------------------------------------------------------------------------
// iae_queue
// Short token queue between the classifier and the execution sequencer.
// ----------------------------------------------------------------------------
module iae_queue import iae_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t wr_tok,
  output logic   full,
  input  logic   pop,
  output logic   rd_valid,
  output token_t rd_tok
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  token_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop_fire;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_tok   = slots[rd_ptr];
  assign pop_fire = pop && rd_valid;

  // token storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_tok;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop_fire) begin
        count <= count + CNT_W'(1);
      end else if (!push && pop_fire) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_W'(QUEUE_DEPTH)) && !(full && push && !pop_fire))
    else $error("token queue overflow");

endmodule

@@ rtl/iae_back.sv @@
// ----------------------------------------------------------------------------
// iae_back
// Execution sequencer: accumulates numbers, applies the pending operator
// with a shift-add multiplier and a restoring divider, and emits the result.
// ----------------------------------------------------------------------------
module iae_back import iae_pkg::*; #(
  parameter int ACC_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      tok_valid,
  input  token_t    tok,
  output logic      tok_pop,
  iae_out_if.source result
);

  localparam int PROD_W    = ACC_WIDTH + NUM_WIDTH;
  localparam int NUM_EXT_W = NUM_WIDTH + 4;
  localparam int CNT_W     = $clog2(ACC_WIDTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPLY  = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_MULFIN = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_DIVFIN = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic [2:0]           state;
  logic [ACC_WIDTH-1:0] sum;
  logic [ACC_WIDTH-1:0] term;
  logic [NUM_WIDTH-1:0] number;
  logic [1:0]           pending;
  logic [1:0]           new_op;
  logic                 have_new_op;
  logic                 fin_req;
  logic                 dz_seen;
  logic                 sat_seen;
  logic                 work_neg;
  logic [PROD_W-1:0]    prod;
  logic [ACC_WIDTH-1:0] mag;
  logic [NUM_WIDTH-1:0] mult;
  logic [NUM_WIDTH-1:0] rem;
  logic [CNT_W-1:0]     step;
  logic                 out_valid;
  logic [31:0]          out_value;
  logic [1:0]           out_status;

  logic [NUM_EXT_W-1:0] num_ext;
  logic                 num_ovf;
  logic [ACC_WIDTH:0]   sum_ext;
  logic                 add_ovf;
  logic [ACC_WIDTH-1:0] sat_sum;
  logic [ACC_WIDTH-1:0] term_mag;
  logic [ACC_WIDTH-1:0] n_ext;
  logic [PROD_W-1:0]    prod_next;
  logic                 mul_pos_ovf;
  logic                 mul_neg_ovf;
  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   diff;
  logic                 div_ge;
  logic                 fits32;
  logic                 fin_go;
  logic [31:0]          total32;

  assign tok_pop = tok_valid && (state == S_IDLE);
  assign fin_go  = (state == S_FIN) && (!out_valid || result.ready);

  assign result.valid  = out_valid;
  assign result.value  = out_value;
  assign result.status = out_status;

  // decimal accumulate with saturation
  assign num_ext = {4'b0, number} * NUM_EXT_W'(DEC_RADIX)
                 + {{(NUM_EXT_W-4){1'b0}}, tok.digit};
  assign num_ovf = |num_ext[NUM_EXT_W-1:NUM_WIDTH];

  // saturating sum + term
  assign sum_ext = {sum[ACC_WIDTH-1], sum} + {term[ACC_WIDTH-1], term};
  assign add_ovf = sum_ext[ACC_WIDTH] != sum_ext[ACC_WIDTH-1];
  assign sat_sum = add_ovf ? (sum_ext[ACC_WIDTH] ? ACC_MIN : ACC_MAX)
                           : sum_ext[ACC_WIDTH-1:0];

  assign term_mag = term[ACC_WIDTH-1] ? ({ACC_WIDTH{1'b0}} - term) : term;
  assign n_ext    = {{(ACC_WIDTH-NUM_WIDTH){1'b0}}, number};

  // shift-add multiply step, multiplier msb first
  assign prod_next = {prod[PROD_W-2:0], 1'b0}
                   + (mult[NUM_WIDTH-1] ? {{NUM_WIDTH{1'b0}}, mag} : {PROD_W{1'b0}});
  assign mul_pos_ovf = prod > {{NUM_WIDTH{1'b0}}, ACC_MAX};
  assign mul_neg_ovf = prod > {{NUM_WIDTH{1'b0}}, ACC_MIN};

  // restoring divide step
  assign trial  = {rem, mag[ACC_WIDTH-1]};
  assign diff   = trial - {1'b0, mult};
  assign div_ge = trial >= {1'b0, mult};

  // clamp the final sum to 32 bits
  assign fits32  = (&sat_sum[ACC_WIDTH-1:31]) || !(|sat_sum[ACC_WIDTH-1:31]);
  assign total32 = fits32 ? sat_sum[31:0]
                          : (sat_sum[ACC_WIDTH-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sum         <= '0;
      term        <= '0;
      number      <= '0;
      pending     <= OP_PLUS;
      new_op      <= OP_PLUS;
      have_new_op <= 1'b0;
      fin_req     <= 1'b0;
      dz_seen     <= 1'b0;
      sat_seen    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (result.ready && !fin_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tok_pop) begin
            fin_req <= tok.fin;
            case (tok.kind)
              KIND_DIGIT: begin
                number <= num_ovf ? {NUM_WIDTH{1'b1}} : num_ext[NUM_WIDTH-1:0];
                if (num_ovf) begin
                  sat_seen <= 1'b1;
                end
                state <= tok.fin ? S_APPLY : S_IDLE;
              end
              KIND_OP: begin
                new_op      <= tok.op;
                have_new_op <= 1'b1;
                state       <= S_APPLY;
              end
              default: begin
                state <= tok.fin ? S_APPLY : S_IDLE;
              end
            endcase
          end
        end
        S_APPLY: begin
          number   <= '0;
          work_neg <= term[ACC_WIDTH-1];
          mag      <= term_mag;
          mult     <= number;
          prod     <= '0;
          rem      <= '0;
          step     <= '0;
          case (pending)
            OP_PLUS: begin
              sum      <= sat_sum;
              sat_seen <= sat_seen || add_ovf;
              term     <= n_ext;
              state    <= S_DONE;
            end
            OP_MINUS: begin
              sum      <= sat_sum;
              sat_seen <= sat_seen || add_ovf;
              term     <= {ACC_WIDTH{1'b0}} - n_ext;
              state    <= S_DONE;
            end
            OP_TIMES: begin
              state <= S_MUL;
            end
            default: begin
              if (number == '0) begin
                dz_seen <= 1'b1;
                state   <= S_DONE;
              end else begin
                state <= S_DIV;
              end
            end
          endcase
        end
        S_MUL: begin
          prod <= prod_next;
          mult <= {mult[NUM_WIDTH-2:0], 1'b0};
          step <= step + CNT_W'(1);
          if (step == CNT_W'(NUM_WIDTH - 1)) begin
            state <= S_MULFIN;
          end
        end
        S_MULFIN: begin
          if (!work_neg && mul_pos_ovf) begin
            term     <= ACC_MAX;
            sat_seen <= 1'b1;
          end else if (work_neg && mul_neg_ovf) begin
            term     <= ACC_MIN;
            sat_seen <= 1'b1;
          end else if (work_neg) begin
            term <= {ACC_WIDTH{1'b0}} - prod[ACC_WIDTH-1:0];
          end else begin
            term <= prod[ACC_WIDTH-1:0];
          end
          state <= S_DONE;
        end
        S_DIV: begin
          rem  <= div_ge ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
          mag  <= {mag[ACC_WIDTH-2:0], div_ge};
          step <= step + CNT_W'(1);
          if (step == CNT_W'(ACC_WIDTH - 1)) begin
            state <= S_DIVFIN;
          end
        end
        S_DIVFIN: begin
          term  <= work_neg ? ({ACC_WIDTH{1'b0}} - mag) : mag;
          state <= S_DONE;
        end
        S_DONE: begin
          if (have_new_op) begin
            pending     <= new_op;
            have_new_op <= 1'b0;
            state       <= fin_req ? S_APPLY : S_IDLE;
          end else begin
            state <= fin_req ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid <= 1'b1;
            out_value <= total32;
            if (dz_seen) begin
              out_status <= STATUS_DIV_ZERO;
            end else if (sat_seen || add_ovf || !fits32) begin
              out_status <= STATUS_SAT;
            end else begin
              out_status <= STATUS_OK;
            end
            sum      <= '0;
            term     <= '0;
            number   <= '0;
            pending  <= OP_PLUS;
            fin_req  <= 1'b0;
            dz_seen  <= 1'b0;
            sat_seen <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (mult != '0))
    else $error("divide started with zero divisor");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> (out_valid && sum == '0 && term == '0 && number == '0
                && pending == OP_PLUS && state == S_IDLE))
    else $error("expression state not cleared after result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_DIV_ZERO
                   || out_status == STATUS_SAT))
    else $error("bad status code");

endmodule

@@ rtl/infix_arith_expression_evaluator_top.sv @@
// ----------------------------------------------------------------------------
// infix_arith_expression_evaluator_top
// Streaming evaluator of decimal expressions with + - * / and two
// precedence levels.
// ----------------------------------------------------------------------------
// Characters enter on chars (ch, last) one item per handshake; ready is high
// whenever the four-entry token queue has room, so the front takes a
// character every cycle until the queue fills. The back pops one token at a
// time and takes no new token until it is back in its idle state. An operator
// character first applies the operator pending before it: + or - and a
// divide by zero go straight to done, * runs the 32-step shift-add
// multiplier, and / runs the restoring divider, one quotient bit per
// cycle. A character with last set adds one more operator application
// and a final cycle that loads the output register; the result item
// (value, status) appears on result the cycle after that. A waiting
// result does not stop token work; only the next final cycle holds until
// the output register is free, and the queue then fills and deasserts
// chars.ready. Synchronous reset clears the accumulators, the pending
// operator (plus), the flags, the queue and the output valid bit.
// ----------------------------------------------------------------------------
module infix_arith_expression_evaluator_top import iae_pkg::*; #(
  parameter int ACC_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  iae_in_if.sink    chars,
  iae_out_if.source result
);

  logic   push;
  logic   full;
  token_t wr_tok;
  logic   pop;
  logic   rd_valid;
  token_t rd_tok;

  // classifier
  iae_front u_front (
    .chars (chars),
    .full  (full),
    .push  (push),
    .tok   (wr_tok)
  );

  // token queue
  iae_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_tok   (wr_tok),
    .full     (full),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_tok   (rd_tok)
  );

  // execution sequencer
  iae_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (rd_valid),
    .tok       (rd_tok),
    .tok_pop   (pop),
    .result    (result)
  );

endmodule
